[rtl/frustum_cull_test_assert.svh]
// Assertion macros shared by the frustum cull test RTL.
`ifndef FRUSTUM_CULL_TEST_ASSERT_SVH
`define FRUSTUM_CULL_TEST_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fct_pkg.sv]
// Types and constants for the frustum cull test.
`timescale 1ns / 1ps
package fct_pkg;

    localparam int PLANE_REGS = 6;
    localparam int PLANE_W    = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int COEF_W     = 16;
    localparam int POS_W      = 16;
    localparam int EXT_W      = 15;
    localparam int CRD_W      = 17;
    localparam int OFF_W      = 17;
    localparam int PROD_W     = CRD_W + COEF_W;
    localparam int SUM_W      = 37;
    localparam int FRAC_SHIFT = 14;
    localparam int S_TDATA_W  = 112;
    localparam int M_TDATA_W  = 8;

    localparam logic FUNC_SPHERE = 1'b0;
    localparam logic FUNC_BOX    = 1'b1;

    typedef logic [PLANE_REGS-1:0][PLANE_W-1:0] plane_array_t;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } stage_en_t;

endpackage

[rtl/fct_plane_regs.sv]
// Plane coefficient registers written through the configuration channel.
`timescale 1ns / 1ps
module fct_plane_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fct_pkg::PLANE_W-1:0]    cfg_data,
    output fct_pkg::plane_array_t          planes
);
    import fct_pkg::*;

    plane_array_t planes_reg;

    assign cfg_ready = 1'b1;
    assign planes    = planes_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            planes_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            for (int i = 0; i < PLANE_REGS; i++) begin
                if (cfg_index == CFG_IDX_W'(i)) begin
                    planes_reg[i] <= cfg_data;
                end
            end
        end
    end

endmodule

[rtl/fct_plane_eval.sv]
// Three-stage test of one object against one plane: corner select, multiply, sum and compare.
`timescale 1ns / 1ps
module fct_plane_eval (
    input  logic                               aclk,
    input  fct_pkg::stage_en_t                 stage_en,
    input  logic [fct_pkg::PLANE_W-1:0]        plane,
    input  logic                               func,
    input  logic signed [fct_pkg::POS_W-1:0]   pos_x,
    input  logic signed [fct_pkg::POS_W-1:0]   pos_y,
    input  logic signed [fct_pkg::POS_W-1:0]   pos_z,
    input  logic [fct_pkg::EXT_W-1:0]          radius,
    input  logic [fct_pkg::EXT_W-1:0]          box_width,
    input  logic [fct_pkg::EXT_W-1:0]          box_height,
    input  logic [fct_pkg::EXT_W-1:0]          box_depth,
    output logic                               cull
);
    import fct_pkg::*;

    logic signed [COEF_W-1:0] coef_a, coef_b, coef_c, coef_d;

    logic signed [CRD_W-1:0]  cx_next, cy_next, cz_next;
    logic signed [OFF_W-1:0]  off_next;
    logic signed [CRD_W-1:0]  cx_reg, cy_reg, cz_reg;
    logic signed [OFF_W-1:0]  off1_reg;
    logic                     func1_reg;

    logic signed [PROD_W-1:0] pa_reg, pb_reg, pc_reg;
    logic signed [OFF_W-1:0]  off2_reg;
    logic                     func2_reg;

    logic signed [SUM_W-1:0]  sum;
    logic                     cull_next;
    logic                     cull_reg;

    assign coef_a = plane[15:0];
    assign coef_b = plane[31:16];
    assign coef_c = plane[47:32];
    assign coef_d = plane[63:48];

    // Sphere mode adds the radius to d; in box mode the corner farthest along the normal decides.
    always_comb begin
        cx_next = CRD_W'(pos_x);
        cy_next = CRD_W'(pos_y);
        cz_next = CRD_W'(pos_z);
        off_next = OFF_W'(coef_d) + $signed({2'b00, radius});
        if (func == FUNC_BOX) begin
            off_next = OFF_W'(coef_d);
            if (!coef_a[COEF_W-1]) cx_next = CRD_W'(pos_x) + $signed({2'b00, box_width});
            if (!coef_b[COEF_W-1]) cy_next = CRD_W'(pos_y) + $signed({2'b00, box_height});
            if (!coef_c[COEF_W-1]) cz_next = CRD_W'(pos_z) + $signed({2'b00, box_depth});
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en.en1) begin
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            cz_reg    <= cz_next;
            off1_reg  <= off_next;
            func1_reg <= func;
        end
        if (stage_en.en2) begin
            pa_reg    <= PROD_W'(coef_a * cx_reg);
            pb_reg    <= PROD_W'(coef_b * cy_reg);
            pc_reg    <= PROD_W'(coef_c * cz_reg);
            off2_reg  <= off1_reg;
            func2_reg <= func1_reg;
        end
        if (stage_en.en3) begin
            cull_reg  <= cull_next;
        end
    end

    // Distance in units of 2^-18; sphere culls on <= 0, box on < 0.
    always_comb begin
        sum = SUM_W'(pa_reg) + SUM_W'(pb_reg) + SUM_W'(pc_reg)
            + $signed({{(SUM_W-OFF_W-FRAC_SHIFT){off2_reg[OFF_W-1]}}, off2_reg,
                       {FRAC_SHIFT{1'b0}}});
        if (func2_reg == FUNC_BOX) begin
            cull_next = sum[SUM_W-1];
        end else begin
            cull_next = sum[SUM_W-1] || (sum == '0);
        end
    end

    assign cull = cull_reg;

endmodule

[rtl/frustum_cull_test.sv]
// Top level of the frustum cull test: handshake, stage valids and result register.
`timescale 1ns / 1ps
// Tests one sphere or axis-aligned box per transaction against the first NUM_PLANES of six
// planes loaded through the configuration channel (a, b, c in Q1.14, d in Q11.4; all math
// exact). A new object is accepted every cycle unless m_tready back-pressure fills the pipeline;
// the result is registered after corner select, one 16x17 multiplier per plane axis, sum and
// compare, then the OR across planes into the output register. Planes reset to zero and must
// only be written while no transaction is in flight.
`include "frustum_cull_test_assert.svh"
module frustum_cull_test #(
    parameter int NUM_PLANES = 6
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pos_x, pos_y, pos_z, radius, box_width, box_height, box_depth, zero pad
    input  logic [fct_pkg::S_TDATA_W-1:0]   s_tdata,
    // func
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // visible, zero pad
    output logic [fct_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fct_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fct_pkg::PLANE_W-1:0]     cfg_data
);
    import fct_pkg::*;

    plane_array_t           planes;
    stage_en_t              stage_en;
    logic [NUM_PLANES-1:0]  cull;

    logic v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic ready1, ready2, ready3, ready4;
    logic visible_reg;

    logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
    logic [EXT_W-1:0]        radius, box_width, box_height, box_depth;

    assign pos_x      = s_tdata[15:0];
    assign pos_y      = s_tdata[31:16];
    assign pos_z      = s_tdata[47:32];
    assign radius     = s_tdata[62:48];
    assign box_width  = s_tdata[77:63];
    assign box_height = s_tdata[92:78];
    assign box_depth  = s_tdata[107:93];

    fct_plane_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .planes    (planes)
    );

    assign ready4 = !m_valid_reg || m_tready;
    assign ready3 = !v3_reg || ready4;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;
    assign s_tready = ready1;

    assign stage_en.en1 = ready1;
    assign stage_en.en2 = ready2;
    assign stage_en.en3 = ready3;

    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
        fct_plane_eval u_eval (
            .aclk       (aclk),
            .stage_en   (stage_en),
            .plane      (planes[p]),
            .func       (s_tuser),
            .pos_x      (pos_x),
            .pos_y      (pos_y),
            .pos_z      (pos_z),
            .radius     (radius),
            .box_width  (box_width),
            .box_height (box_height),
            .box_depth  (box_depth),
            .cull       (cull[p])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ready1) v1_reg      <= s_tvalid;
            if (ready2) v2_reg      <= v1_reg;
            if (ready3) v3_reg      <= v2_reg;
            if (ready4) m_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready4) begin
            visible_reg <= !(|cull);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, visible_reg};

    `FCT_ASSERT_NOW(a_stall_only_when_full, !s_tready, v1_reg && v2_reg && v3_reg && m_valid_reg, "input stalled with a free stage")
    `FCT_ASSERT_NEXT(a_accept_fills_s1, aresetn && s_tvalid && s_tready, v1_reg, "accepted transaction lost at stage 1")
    `FCT_ASSERT_NEXT(a_s3_to_out, aresetn && v3_reg && ready3, m_tvalid, "stage 3 result did not reach output")
    `FCT_ASSERT_NEXT(a_oob_cfg_ignored, aresetn && cfg_valid && cfg_ready && (cfg_index >= CFG_IDX_W'(PLANE_REGS)), $stable(planes), "out-of-range write changed a plane")

endmodule
